/* rtl/lss_pkg.sv */
// lss_pkg: shared types and constants for the LED script sequencer.
// No dependencies; every other file of the block refers to it by scoped names.

package lss_pkg;

	localparam logic [31:0] MAGIC_WORD   = 32'h13a0_fe89;
	localparam int unsigned POS_W        = 10;
	localparam int unsigned ELAPSED_W    = 25;
	localparam int unsigned WAIT_W       = 24;
	localparam int unsigned LIGHT_W      = 4;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

	typedef enum logic [7:0] {
		OPC_LEDS  = 8'h00,
		OPC_LAMPS = 8'h01,
		OPC_WAIT  = 8'h02,
		OPC_LOOP  = 8'h03
	} opcode_t;

	// Item kinds carried in s_tuser
	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// One result beat
	typedef struct packed {
		logic               script_valid;
		logic               waiting;
		logic [POS_W-1:0]   position;
		logic [LIGHT_W-1:0] lamp_bits;
		logic [LIGHT_W-1:0] led_bits;
	} result_t;

endpackage

/* rtl/lss_store.sv */
// lss_store: script word memory with one write and one registered read port,
// clearing sweep after reset, read-during-write forwarding and magic flag.
// Depends on lss_pkg.

module lss_store #(
	parameter int unsigned SCRIPT_WORDS = 1024,
	parameter int unsigned AW           = $clog2(SCRIPT_WORDS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_word,
	output logic          clearing,
	output logic          magic_q,
	output logic          magic_d
);

	localparam logic [AW-1:0] LAST_IDX = AW'(SCRIPT_WORDS - 1);

	logic [31:0]   mem [SCRIPT_WORDS];
	logic [31:0]   rd_q;
	logic [31:0]   fwd_q;
	logic          fwd_hit_q;
	logic          clearing_q;
	logic [AW-1:0] clr_idx_q;

	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [31:0]   mem_wd;

	assign mem_we   = clearing_q | wr_en;
	assign mem_wa   = clearing_q ? clr_idx_q : wr_addr;
	assign mem_wd   = clearing_q ? 32'd0 : wr_data;
	assign clearing = clearing_q;
	assign rd_word  = fwd_hit_q ? fwd_q : rd_q;
	assign magic_d  = (wr_en && wr_addr == '0) ? (wr_data == lss_pkg::MAGIC_WORD) : magic_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q  <= mem[rd_addr];
		fwd_q <= mem_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
			fwd_hit_q  <= 1'b0;
			magic_q    <= 1'b0;
		end else begin
			// a write to the word being fetched wins over the old memory data
			fwd_hit_q <= mem_we && (mem_wa == rd_addr);
			magic_q   <= magic_d;
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + AW'(1);
				if (clr_idx_q == LAST_IDX) begin
					clearing_q <= 1'b0;
				end
			end
		end
	end

endmodule

/* rtl/lss_exec.sv */
// lss_exec: sequencer state registers and the execute step of one tick.
// Depends on lss_pkg; takes the prefetched word from lss_store.

module lss_exec #(
	parameter int unsigned SCRIPT_WORDS = 1024,
	parameter int unsigned AW           = $clog2(SCRIPT_WORDS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick_en,
	input  logic [31:0]         cur_word,
	input  logic                magic_q,
	input  logic                magic_d,
	output logic [AW-1:0]       fetch_addr,
	output lss_pkg::result_t    result
);

	localparam logic [AW-1:0] LAST_IDX  = AW'(SCRIPT_WORDS - 1);
	localparam logic [AW-1:0] FIRST_OP  = AW'(2);

	logic [AW-1:0]                    pos_q, pos_d, pos_eff, pos_adv;
	logic                             waiting_q, waiting_d;
	logic [lss_pkg::ELAPSED_W-1:0]    el_q, el_d, el_inc;
	logic [lss_pkg::WAIT_W-1:0]       wlen_q, wlen_d;
	logic [lss_pkg::LIGHT_W-1:0]      led_q, led_d, lamp_q, lamp_d;
	logic [7:0]                       opc;
	logic                             run;

	assign opc     = cur_word[31:24];
	// header skip: position 0 executes from word 2
	assign pos_eff = (pos_q == '0) ? FIRST_OP : pos_q;
	assign pos_adv = (pos_eff == LAST_IDX) ? '0 : pos_eff + AW'(1);
	assign el_inc  = (waiting_q && el_q != lss_pkg::ELAPSED_MAX) ?
		el_q + lss_pkg::ELAPSED_W'(1) : el_q;

	always_comb begin
		pos_d     = pos_q;
		waiting_d = waiting_q;
		el_d      = el_q;
		wlen_d    = wlen_q;
		led_d     = led_q;
		lamp_d    = lamp_q;
		run       = 1'b0;
		if (tick_en) begin
			el_d = el_inc;
			if (pos_q != '0 || magic_q) begin
				pos_d = pos_eff;
				if (!waiting_q) begin
					run = 1'b1;
				end else if (el_inc > {1'b0, wlen_q}) begin
					waiting_d = 1'b0;
					run       = 1'b1;
				end
			end
			if (run) begin
				pos_d = pos_adv;
				case (opc)
					lss_pkg::OPC_LEDS:  led_d  = cur_word[lss_pkg::LIGHT_W-1:0];
					lss_pkg::OPC_LAMPS: lamp_d = cur_word[lss_pkg::LIGHT_W-1:0];
					lss_pkg::OPC_WAIT: begin
						waiting_d = 1'b1;
						el_d      = '0;
						wlen_d    = cur_word[lss_pkg::WAIT_W-1:0];
					end
					lss_pkg::OPC_LOOP:  pos_d  = '0;
					default: ;
				endcase
			end
		end
	end

	// prefetch the word the next tick will execute
	assign fetch_addr = (pos_d == '0) ? FIRST_OP : pos_d;

	always_comb begin
		result.led_bits     = led_d;
		result.lamp_bits    = lamp_d;
		result.position     = lss_pkg::POS_W'(pos_d);
		result.waiting      = waiting_d;
		result.script_valid = magic_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			waiting_q <= 1'b0;
			el_q      <= '0;
			wlen_q    <= '0;
			led_q     <= '0;
			lamp_q    <= '0;
		end else begin
			pos_q     <= pos_d;
			waiting_q <= waiting_d;
			el_q      <= el_d;
			wlen_q    <= wlen_d;
			led_q     <= led_d;
			lamp_q    <= lamp_d;
		end
	end

endmodule

/* rtl/lss_outbuf.sv */
// lss_outbuf: two-entry result buffer between the execute step and the
// master side. Depends on lss_pkg.

module lss_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lss_pkg::result_t push_data,
	output logic             has_room,
	output logic             out_valid,
	output lss_pkg::result_t out_data,
	input  logic             out_ready
);

	lss_pkg::result_t slot_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             pop;

	assign has_room  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/led_script_sequencer.sv */
// led_script_sequencer: top level, light script runner.
// Depends on lss_pkg, lss_store, lss_exec and lss_outbuf.
//
// Usage
//  Slave side (s_*): one beat per item. s_tuser = kind (0 tick, 1 write word).
//  s_tdata, lowest bit up: word_index[9:0], word_value[41:10], zero pad to 48.
//  Master side (m_*): one result beat per accepted item, in order, holding the
//  light, position, wait and header state after that item.
//  m_tdata, lowest bit up: led_bits[3:0], lamp_bits[7:4], position[17:8],
//  waiting[18], script_valid[19], zero pad to 24.
//  Throughput: one item per cycle while s_tready is high, ticks and writes
//  mixed freely. The word a tick executes is prefetched from the script
//  memory in the cycle before, so the single read port sets the rate;
//  writes to that word are forwarded.
//  Reset: script memory is swept to zero, one word a cycle, over all
//  SCRIPT_WORDS words; s_tready stays low until the sweep ends.
//  Stall: a two-beat result buffer lets items keep flowing while one result
//  waits; s_tready drops only once both entries are full.

module led_script_sequencer #(
	parameter int unsigned SCRIPT_WORDS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // word_index[9:0], word_value[41:10]
	input  logic [0:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // led, lamp, position, waiting, script_valid
);

	localparam int unsigned AW = $clog2(SCRIPT_WORDS);

	logic                 accept, tick_en, wr_en, in_range;
	logic [9:0]           word_index;
	logic [31:0]          word_value;
	logic [31:0]          cur_word;
	logic [AW-1:0]        fetch_addr;
	logic                 clearing, magic_q, magic_d, has_room;
	lss_pkg::result_t     result, out_res;

	assign word_index = s_tdata[9:0];
	assign word_value = s_tdata[41:10];

	// indexes past the end of the store are dropped
	assign in_range = (17'(word_index) < 17'(SCRIPT_WORDS));

	assign s_tready = !clearing && has_room;
	assign accept   = s_tvalid && s_tready;
	assign tick_en  = accept && (s_tuser[0] == lss_pkg::KIND_TICK);
	assign wr_en    = accept && (s_tuser[0] == lss_pkg::KIND_WRITE) && in_range;

	lss_store #(
		.SCRIPT_WORDS (SCRIPT_WORDS),
		.AW           (AW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (AW'(word_index)),
		.wr_data  (word_value),
		.rd_addr  (fetch_addr),
		.rd_word  (cur_word),
		.clearing (clearing),
		.magic_q  (magic_q),
		.magic_d  (magic_d)
	);

	lss_exec #(
		.SCRIPT_WORDS (SCRIPT_WORDS),
		.AW           (AW)
	) u_exec (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_en    (tick_en),
		.cur_word   (cur_word),
		.magic_q    (magic_q),
		.magic_d    (magic_d),
		.fetch_addr (fetch_addr),
		.result     (result)
	);

	lss_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.has_room  (has_room),
		.out_valid (m_tvalid),
		.out_data  (out_res),
		.out_ready (m_tready)
	);

	assign m_tdata = {4'd0, out_res.script_valid, out_res.waiting, out_res.position,
		out_res.lamp_bits, out_res.led_bits};

endmodule
